// ----- hw/rtl/rds_pkg.sv -----
// Shared types, constants and calendar helpers for the recurrence date stepper.
package rds_pkg;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_MAR = 4'd3;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  DAY_FIRST = 5'd1;
    localparam logic [4:0]  DAY_LEAP  = 5'd29;
    localparam logic [4:0]  DAY_LAST  = 5'd31;

    // Reciprocal of 100 scaled by 2^19, exact for every 14-bit year
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [1:0] CFG_END_YEAR  = 2'd0;
    localparam logic [1:0] CFG_END_MONTH = 2'd1;
    localparam logic [1:0] CFG_END_DAY   = 2'd2;

    typedef enum logic [1:0] {
        MODE_DAILY   = 2'd0,
        MODE_WEEKLY  = 2'd1,
        MODE_MONTHLY = 2'd2,
        MODE_YEARLY  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        mode_t       mode;
    } date_in_t;

    typedef struct packed {
        logic [13:0] next_year;
        logic [3:0]  next_month;
        logic [4:0]  next_day;
        logic        in_range;
    } date_out_t;

    // Cleaned-up date handed from the input stage to the step stage
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  len;
        logic        leap_cur;
        logic        leap_next;
        mode_t       mode;
    } prep_t;

    // Gregorian leap test; the year is split by 100 through the reciprocal
    function automatic logic leap_year(input logic [13:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] rem;
        prod = y * RECIP_100;
        q    = prod[RECIP_SHIFT +: 8];
        rem  = y - (14'(q) * 14'd100);
        return ((y[1:0] == 2'd0) && (rem != 14'd0)) ||
               ((rem == 14'd0) && (q[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
            default:                 len = DAY_LAST;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/rds_in_if.sv -----
// Input channel carrying one date and step mode per transfer.
interface rds_in_if
    import rds_pkg::*;
();
    logic     valid;
    logic     ready;
    date_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rds_out_if.sv -----
// Output channel carrying one stepped date and range flag per transfer.
interface rds_out_if
    import rds_pkg::*;
();
    logic      valid;
    logic      ready;
    date_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rds_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface rds_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [13:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

// ----- hw/rtl/rds_prep.sv -----
// Input stage: clamps the incoming date, finds month length and leap flags.
module rds_prep
    import rds_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rds_in_if.sink dates,
    output prep_t  stage_data,
    output logic   stage_valid,
    input  logic   stage_ready
);

    logic        valid_reg;
    logic        valid_next;
    prep_t       data_reg;
    prep_t       data_next;
    logic [13:0] year_c;
    logic [3:0]  month_c;
    logic [4:0]  len_c;
    logic        leap_c;
    logic        take;

    assign dates.ready = !valid_reg || stage_ready;
    assign take        = dates.valid && dates.ready;

    // Clamp year and month, then the day to the month's length
    always_comb
    begin
        year_c = (dates.data.cur_year > YEAR_MAX) ? YEAR_MAX : dates.data.cur_year;
        if (dates.data.cur_month < MONTH_JAN)
            month_c = MONTH_JAN;
        else if (dates.data.cur_month > MONTH_DEC)
            month_c = MONTH_DEC;
        else
            month_c = dates.data.cur_month;
        leap_c = leap_year(year_c);
        len_c  = month_len(month_c, leap_c);

        data_next.year      = year_c;
        data_next.month     = month_c;
        data_next.len       = len_c;
        data_next.leap_cur  = leap_c;
        data_next.leap_next = leap_year(year_c + 14'd1);
        data_next.mode      = dates.data.mode;
        if (dates.data.cur_day < DAY_FIRST)
            data_next.day = DAY_FIRST;
        else if (dates.data.cur_day > len_c)
            data_next.day = len_c;
        else
            data_next.day = dates.data.cur_day;
    end

    // Hold the stage while the step stage is stalled
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (stage_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= data_next;
    end

    assign stage_data  = data_reg;
    assign stage_valid = valid_reg;

`ifndef SYNTHESIS
    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("rds_prep: accepted transfer not held in stage");
    a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.day >= DAY_FIRST) && (data_reg.day <= data_reg.len))
        else $error("rds_prep: clamped day outside month");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !stage_ready) |=> valid_reg && $stable(data_reg))
        else $error("rds_prep: stalled stage changed");
`endif

endmodule

// ----- hw/rtl/rds_step.sv -----
// Step stage: advances the date by mode, checks the end date, holds the result.
module rds_step
    import rds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  prep_t       stage_data,
    input  logic        stage_valid,
    output logic        stage_ready,
    input  logic [13:0] end_year,
    input  logic [3:0]  end_month,
    input  logic [4:0]  end_day,
    rds_out_if.source   steps
);

    logic        valid_reg;
    logic        valid_next;
    date_out_t   data_reg;
    date_out_t   data_next;
    logic [13:0] y_inc;
    logic [3:0]  m_adv;
    logic [13:0] y_adv;
    logic [5:0]  dsum;
    logic [4:0]  nlen;
    logic [13:0] y_n;
    logic [3:0]  m_n;
    logic [4:0]  d_n;
    logic        take;

    assign stage_ready = !valid_reg || steps.ready;
    assign take        = stage_valid && stage_ready;

    // Following month, carrying into the next year after December
    always_comb
    begin
        y_inc = stage_data.year + 14'd1;
        if (stage_data.month >= MONTH_DEC)
        begin
            m_adv = MONTH_JAN;
            y_adv = y_inc;
        end
        else
        begin
            m_adv = stage_data.month + 4'd1;
            y_adv = stage_data.year;
        end
        nlen = (stage_data.month >= MONTH_DEC) ? DAY_LAST
                                               : month_len(m_adv, stage_data.leap_cur);
        dsum = {1'b0, stage_data.day} +
               ((stage_data.mode == MODE_DAILY) ? 6'd1 : 6'd7);
    end

    // Apply the step for the selected mode
    always_comb
    begin
        y_n = stage_data.year;
        m_n = stage_data.month;
        d_n = stage_data.day;
        case (stage_data.mode)
            MODE_DAILY, MODE_WEEKLY:
            begin
                if (dsum > {1'b0, stage_data.len})
                begin
                    d_n = 5'(dsum - {1'b0, stage_data.len});
                    y_n = y_adv;
                    m_n = m_adv;
                end
                else
                    d_n = dsum[4:0];
            end
            MODE_MONTHLY:
            begin
                y_n = y_adv;
                m_n = m_adv;
                d_n = (stage_data.day > nlen) ? nlen : stage_data.day;
            end
            MODE_YEARLY:
            begin
                y_n = y_inc;
                if ((stage_data.month == MONTH_FEB) && (stage_data.day == DAY_LEAP) &&
                    !stage_data.leap_next)
                begin
                    m_n = MONTH_MAR;
                    d_n = DAY_FIRST;
                end
            end
            default:
            begin
                y_n = stage_data.year;
            end
        endcase
    end

    // Saturate on year overflow, else compare against the end date
    always_comb
    begin
        if (y_n > YEAR_MAX)
        begin
            data_next.next_year  = YEAR_MAX;
            data_next.next_month = MONTH_DEC;
            data_next.next_day   = DAY_LAST;
            data_next.in_range   = 1'b0;
        end
        else
        begin
            data_next.next_year  = y_n;
            data_next.next_month = m_n;
            data_next.next_day   = d_n;
            if (y_n != end_year)
                data_next.in_range = (y_n < end_year);
            else if (m_n != end_month)
                data_next.in_range = (m_n < end_month);
            else
                data_next.in_range = (d_n <= end_day);
        end
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (steps.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= data_next;
    end

    assign steps.valid = valid_reg;
    assign steps.data  = data_reg;

`ifndef SYNTHESIS
    a_year_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.next_year <= YEAR_MAX))
        else $error("rds_step: result year above limit");
    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.next_month >= MONTH_JAN) &&
                      (data_reg.next_month <= MONTH_DEC) &&
                      (data_reg.next_day >= DAY_FIRST))
        else $error("rds_step: result date malformed");
    a_stage_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("rds_step: taken item not presented");
`endif

endmodule

// ----- hw/rtl/recurrence_date_stepper.sv -----
// Recurrence date stepper: steps a date by day, week, month or year.
//
// Channels: dates carries cur_year, cur_month, cur_day and mode per transfer;
// steps returns next_year, next_month, next_day and in_range, one result
// per input, in order. cfg writes the end date: index 0 end_year,
// 1 end_month, 2 end_day; other indexes are ignored. cfg is always ready;
// the user must write it only while no date is in flight, and the block
// has no check for this. A date passes through the input stage register,
// then the result register. Throughput: one date per cycle while steps.ready
// holds, set by the two-register pipeline with no iteration.
// Out-of-range inputs are clamped to the nearest valid date first. A stepped
// year past 9999 gives 9999-12-31 with in_range low.
// Reset clears both stage valid flags and loads the end date 9999-12-31.
// When the receiver stalls, the result register holds and the input stage
// keeps accepting until it too is full; then dates.ready drops.
module recurrence_date_stepper
    import rds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rds_in_if.sink     dates,
    rds_out_if.source  steps,
    rds_cfg_if.sink    cfg
);

    logic [13:0] end_year_reg;
    logic [3:0]  end_month_reg;
    logic [4:0]  end_day_reg;
    prep_t       stage_data;
    logic        stage_valid;
    logic        stage_ready;

    assign cfg.ready = 1'b1;

    // Write the end date registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_year_reg  <= YEAR_MAX;
            end_month_reg <= MONTH_DEC;
            end_day_reg   <= DAY_LAST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_END_YEAR:  end_year_reg  <= cfg.value;
                CFG_END_MONTH: end_month_reg <= cfg.value[3:0];
                CFG_END_DAY:   end_day_reg   <= cfg.value[4:0];
                default:       end_year_reg  <= end_year_reg;
            endcase
        end
    end

    rds_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .dates       (dates),
        .stage_data  (stage_data),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready)
    );

    rds_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_data  (stage_data),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .end_year    (end_year_reg),
        .end_month   (end_month_reg),
        .end_day     (end_day_reg),
        .steps       (steps)
    );

endmodule

// ----- tb/recurrence_date_stepper_test.sv -----
// Testbench for the recurrence date stepper: directed table, then random dates per end-date phase.
`timescale 1ns / 1ps

module recurrence_date_stepper_test;
    import rds_pkg::*;

    localparam int NUM_DIRECTED   = 25;
    localparam int NUM_PHASES     = 7;
    localparam int DATES_PER_PHASE = 100;
    localparam int WATCHDOG_LIMIT = 1000;

    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        date_in_t  stim;
        logic      has_want;
        date_out_t want;
    } date_case_t;

    // Rows with has_want set run under the reset end date 9999-12-31
    localparam date_case_t DIRECTED [NUM_DIRECTED] = '{
        '{'{14'd2023, 4'd12, 5'd31, MODE_DAILY},   1'b1, '{14'd2024, 4'd1,  5'd1,  1'b1}},
        '{'{14'd2024, 4'd2,  5'd28, MODE_DAILY},   1'b1, '{14'd2024, 4'd2,  5'd29, 1'b1}},
        '{'{14'd1900, 4'd2,  5'd28, MODE_DAILY},   1'b1, '{14'd1900, 4'd3,  5'd1,  1'b1}},
        '{'{14'd2000, 4'd2,  5'd28, MODE_DAILY},   1'b1, '{14'd2000, 4'd2,  5'd29, 1'b1}},
        '{'{14'd9999, 4'd12, 5'd31, MODE_DAILY},   1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
        '{'{14'd9999, 4'd12, 5'd28, MODE_WEEKLY},  1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
        '{'{14'd2024, 4'd12, 5'd28, MODE_WEEKLY},  1'b1, '{14'd2025, 4'd1,  5'd4,  1'b1}},
        '{'{14'd2024, 4'd1,  5'd31, MODE_MONTHLY}, 1'b1, '{14'd2024, 4'd2,  5'd29, 1'b1}},
        '{'{14'd2023, 4'd1,  5'd31, MODE_MONTHLY}, 1'b1, '{14'd2023, 4'd2,  5'd28, 1'b1}},
        '{'{14'd9999, 4'd12, 5'd1,  MODE_MONTHLY}, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
        '{'{14'd2024, 4'd2,  5'd29, MODE_YEARLY},  1'b1, '{14'd2025, 4'd3,  5'd1,  1'b1}},
        '{'{14'd9999, 4'd6,  5'd15, MODE_YEARLY},  1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
        '{'{14'd0,    4'd1,  5'd1,  MODE_DAILY},   1'b1, '{14'd0,    4'd1,  5'd2,  1'b1}},
        '{'{14'd16383, 4'd15, 5'd31, MODE_DAILY},  1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
        '{'{14'd0,    4'd0,  5'd0,  MODE_YEARLY},  1'b1, '{14'd1,    4'd1,  5'd1,  1'b1}},
        '{'{14'd2024, 4'd4,  5'd31, MODE_DAILY},   1'b1, '{14'd2024, 4'd5,  5'd1,  1'b1}},
        '{'{14'd0,    4'd2,  5'd29, MODE_WEEKLY},  1'b1, '{14'd0,    4'd3,  5'd7,  1'b1}},
        '{'{14'd2100, 4'd2,  5'd29, MODE_MONTHLY}, 1'b1, '{14'd2100, 4'd3,  5'd28, 1'b1}},
        '{'{14'd2400, 4'd2,  5'd29, MODE_YEARLY},  1'b1, '{14'd2401, 4'd3,  5'd1,  1'b1}},
        '{'{14'd2023, 4'd2,  5'd29, MODE_YEARLY},  1'b0, '0},
        '{'{14'd16383, 4'd13, 5'd30, MODE_MONTHLY}, 1'b0, '0},
        '{'{14'd5000, 4'd7,  5'd17, MODE_WEEKLY},  1'b0, '0},
        '{'{14'd1999, 4'd9,  5'd30, MODE_WEEKLY},  1'b0, '0},
        '{'{14'd10000, 4'd12, 5'd31, MODE_YEARLY}, 1'b0, '0},
        '{'{14'd9998, 4'd12, 5'd31, MODE_DAILY},   1'b0, '0}
    };

    logic clk;
    logic rst_n;

    rds_in_if  dates_ch ();
    rds_out_if steps_ch ();
    rds_cfg_if cfg_ch ();

    // End date as the block should hold it
    logic [13:0] end_year_q;
    logic [3:0]  end_month_q;
    logic [4:0]  end_day_q;

    date_out_t pending_steps[$];
    int        fail_count;
    int        quiet_cycles;
    bit        idle_on;

    recurrence_date_stepper u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .dates (dates_ch),
        .steps (steps_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in(input int y, input int m);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic void roll_month(inout int y, inout int m);
        if (m >= 12)
        begin
            m = 1;
            y++;
        end
        else
        begin
            m++;
        end
    endfunction

    // Next occurrence of a date and its position against the end date
    function automatic date_out_t step_date(input date_in_t in);
        date_out_t res;
        int        y;
        int        m;
        int        d;
        int        len;
        bit        ok;
        y = in.cur_year;
        m = in.cur_month;
        d = in.cur_day;
        // Clamp the input to a real date
        if (y > 9999) y = 9999;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        len = days_in(y, m);
        if (d < 1) d = 1;
        if (d > len) d = len;
        case (in.mode)
            MODE_DAILY, MODE_WEEKLY:
            begin
                d += (in.mode == MODE_DAILY) ? 1 : 7;
                if (d > len)
                begin
                    d -= len;
                    roll_month(y, m);
                end
            end
            MODE_MONTHLY:
            begin
                roll_month(y, m);
                len = days_in(y, m);
                if (d > len) d = len;
            end
            default:
            begin
                y++;
                if (m == 2 && d == 29 && !is_leap(y))
                begin
                    m = 3;
                    d = 1;
                end
            end
        endcase
        // Saturate on year overflow, else order against the end date
        if (y > 9999)
        begin
            y  = 9999;
            m  = 12;
            d  = 31;
            ok = 1'b0;
        end
        else if (y != int'(end_year_q))
            ok = y < int'(end_year_q);
        else if (m != int'(end_month_q))
            ok = m < int'(end_month_q);
        else
            ok = d <= int'(end_day_q);
        res.next_year  = 14'(y);
        res.next_month = 4'(m);
        res.next_day   = 5'(d);
        res.in_range   = ok;
        return res;
    endfunction

    // Random date, biased toward the end date, month ends and overflow years
    function automatic date_in_t make_date();
        date_in_t d;
        int       y;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            y = int'(end_year_q) + int'($urandom_range(0, 4)) - 2;
            if (y < 0) y = 0;
            if (y > 16383) y = 16383;
        end
        else if (pick < 55)
            y = $urandom_range(9995, 9999);
        else if (pick < 65)
            y = 100 * $urandom_range(0, 99);
        else if (pick < 72)
            y = $urandom_range(10000, 16383);
        else
            y = $urandom_range(0, 9999);
        d.cur_year = 14'(y);
        if (pick < 40 && $urandom_range(0, 1) == 1)
            d.cur_month = end_month_q;
        else if ($urandom_range(0, 9) == 0)
            d.cur_month = 4'($urandom_range(0, 15));
        else
            d.cur_month = 4'($urandom_range(1, 12));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            d.cur_day = 5'($urandom_range(26, 31));
        else if (pick < 9)
            d.cur_day = 5'($urandom_range(1, 31));
        else
            d.cur_day = 5'($urandom_range(0, 31));
        d.mode = mode_t'($urandom_range(0, 3));
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one date at a falling edge, hold until the transfer, record the expectation
    task automatic send_date(input date_in_t d, input logic has_want, input date_out_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            dates_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        dates_ch.valid <= 1'b1;
        dates_ch.data  <= d;
        do @(posedge clk); while (!dates_ch.ready);
        if (has_want)
            pending_steps = {pending_steps, want};
        else
            pending_steps = {pending_steps, step_date(d)};
        @(negedge clk);
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic cfg_write(input logic [1:0] idx, input logic [13:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.value <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_END_YEAR:  end_year_q  = val;
            CFG_END_MONTH: end_month_q = val[3:0];
            CFG_END_DAY:   end_day_q   = val[4:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Main sequence: reset, directed table, then random phases
    initial
    begin
        int       n;
        int       phase;
        date_in_t d;
        rst_n          = 1'b0;
        dates_ch.valid = 1'b0;
        dates_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_END_YEAR;
        cfg_ch.value   = '0;
        end_year_q     = YEAR_MAX;
        end_month_q    = MONTH_DEC;
        end_day_q      = DAY_LAST;
        idle_on        = 1'b1;
        fail_count     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < NUM_DIRECTED; n++)
            send_date(DIRECTED[n].stim, DIRECTED[n].has_want, DIRECTED[n].want);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Drain before touching the end date
            dates_ch.valid <= 1'b0;
            wait (pending_steps.size() == 0);
            repeat (4) @(negedge clk);
            case (phase)
                0:
                begin
                    cfg_write(CFG_END_YEAR, 14'd0);
                    cfg_write(CFG_END_MONTH, 14'(MONTH_JAN));
                    cfg_write(CFG_END_DAY, 14'(DAY_FIRST));
                end
                1:
                begin
                    cfg_write(CFG_END_YEAR, 14'h3fff);
                    cfg_write(CFG_END_MONTH, 14'd15);
                    cfg_write(CFG_END_DAY, 14'(DAY_LAST));
                end
                2:
                begin
                    cfg_write(CFG_END_YEAR, 14'($urandom_range(0, 9999)));
                    cfg_write(CFG_END_MONTH, 14'd0);
                    cfg_write(CFG_END_DAY, 14'd0);
                end
                3:
                begin
                    cfg_write(CFG_END_YEAR, YEAR_MAX);
                    cfg_write(CFG_END_MONTH, 14'(MONTH_DEC));
                    cfg_write(CFG_END_DAY, 14'(DAY_LAST));
                    cfg_write(CFG_UNMAPPED, 14'($urandom_range(0, 16383)));
                end
                5:
                begin
                    // Full-width values; upper bits must be dropped
                    cfg_write(CFG_END_YEAR, 14'($urandom_range(0, 16383)));
                    cfg_write(CFG_END_MONTH, 14'($urandom_range(0, 16383)));
                    cfg_write(CFG_END_DAY, 14'($urandom_range(0, 16383)));
                end
                default:
                begin
                    cfg_write(CFG_END_YEAR, 14'($urandom_range(0, 9999)));
                    cfg_write(CFG_END_MONTH, 14'($urandom_range(1, 12)));
                    cfg_write(CFG_END_DAY, 14'($urandom_range(1, 31)));
                end
            endcase
            cfg_ch.valid <= 1'b0;
            idle_on = (phase != 2) && (phase != 5);
            repeat (DATES_PER_PHASE)
            begin
                d = make_date();
                send_date(d, 1'b0, '0);
            end
        end

        dates_ch.valid <= 1'b0;
        wait (pending_steps.size() == 0);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result ready: short stalls mostly, a few long ones, and stall-free stretches
    initial
    begin
        int r;
        int hold;
        steps_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                steps_ch.ready <= 1'b1;
                hold = $urandom_range(1, 8);
            end
            else if (r < 80)
            begin
                steps_ch.ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end
            else if (r < 90)
            begin
                steps_ch.ready <= 1'b1;
                hold = $urandom_range(30, 120);
            end
            else if (r < 97)
            begin
                steps_ch.ready <= 1'b0;
                hold = $urandom_range(4, 12);
            end
            else
            begin
                steps_ch.ready <= 1'b0;
                hold = $urandom_range(30, 60);
            end
            repeat (hold) @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        date_out_t want;
        if (rst_n && steps_ch.valid && steps_ch.ready)
        begin
            if (pending_steps.size() == 0)
            begin
                $display("%0t ns: unexpected result %0d-%0d-%0d in_range %0b", $time,
                         steps_ch.data.next_year, steps_ch.data.next_month,
                         steps_ch.data.next_day, steps_ch.data.in_range);
                fail_count++;
            end
            else
            begin
                want = pending_steps.pop_front();
                if (steps_ch.data !== want)
                begin
                    $display("%0t ns: mismatch, expected %0d-%0d-%0d in_range %0b,",
                             $time, want.next_year, want.next_month, want.next_day,
                             want.in_range, " got %0d-%0d-%0d in_range %0b",
                             steps_ch.data.next_year, steps_ch.data.next_month,
                             steps_ch.data.next_day, steps_ch.data.in_range);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no channel transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (dates_ch.valid && dates_ch.ready) ||
            (steps_ch.valid && steps_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- filelist.f -----
hw/rtl/rds_pkg.sv
hw/rtl/rds_in_if.sv
hw/rtl/rds_out_if.sv
hw/rtl/rds_cfg_if.sv
hw/rtl/rds_prep.sv
hw/rtl/rds_step.sv
hw/rtl/recurrence_date_stepper.sv
tb/recurrence_date_stepper_test.sv
